// ===== rtl/mrp_pkg.sv =====
// Shared types, constants and constant functions of the pair rotator.
package mrp_pkg;

   // register map, word index from paddr[3:2]
   localparam logic [1:0] REG_ROTARY_PAIRS  = 2'd0;
   localparam logic [1:0] REG_TEMPORAL_PAIRS = 2'd1;
   localparam logic [1:0] REG_HEIGHT_PAIRS  = 2'd2;
   localparam logic [1:0] REG_FREQ_STEP     = 2'd3;

   localparam int QDEPTH = 4;
   localparam int ROOT_STEPS = 20;
   localparam int WORK_SHIFT = 14;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
   localparam logic signed [31:0] CORDIC_GAIN_Q31 = 32'sd1304065748;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic [5:0]         pair_index;
      logic [19:0]        pos_temporal;
      logic [19:0]        pos_height;
      logic [19:0]        pos_width;
      logic signed [15:0] elem_even;
      logic signed [15:0] elem_odd;
   } mrp_req_type;

   typedef struct packed {
      logic signed [15:0] out_even;
      logic signed [15:0] out_odd;
   } mrp_rsp_type;

   typedef struct packed {
      logic [6:0]  rotary_pairs;
      logic [6:0]  temporal_pairs;
      logic [6:0]  height_pairs;
      logic [25:0] freq_exponent_step;
   } mrp_cfg_type;

   // classified pair as it waits between front and back
   typedef struct packed {
      logic               pass;
      logic [11:0]        exp_int;
      logic [19:0]        exp_frac;
      logic [19:0]        pos;
      logic signed [15:0] elem_a;
      logic signed [15:0] elem_b;
   } mrp_item_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic [2:0] count;
   } mrp_qstat_type;

   // bitwise integer square root
   function automatic logic [63:0] mrp_isqrt(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v = value;
      res = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^31 * 2^(-2^-k), built by repeated square roots from 2^30
   function automatic logic [31:0] mrp_root(input int k);
      logic [63:0] t;
      t = 64'd1 << 30;
      for (int i = 1; i <= ROOT_STEPS; i++) begin
         if (i <= k) begin
            t = mrp_isqrt(t << 31);
         end
      end
      return t[31:0];
   endfunction

endpackage

// ===== rtl/mrp_front.sv =====
// Front end: classifies a pair into pass-through or section, picks its position
// and forms the frequency exponent.
module mrp_front import mrp_pkg::*; #(
   parameter int MAX_PAIRS = 64
) (
   input  mrp_req_type  req,
   input  mrp_cfg_type  cfg,
   output mrp_item_type item
);

   logic [5:0]  p;
   logic [7:0]  cut2;
   logic [7:0]  diff2;
   logic [6:0]  diff1;
   logic [5:0]  local_idx;
   logic [19:0] pos_sel;
   logic [31:0] expo;

   assign p     = req.pair_index;
   assign cut2  = {1'b0, cfg.temporal_pairs} + {1'b0, cfg.height_pairs};
   assign diff2 = {2'b00, p} - cut2;
   assign diff1 = {1'b0, p} - cfg.temporal_pairs;

   // section select, local index restarts in each section
   always_comb begin
      if ({2'b00, p} >= cut2) begin
         local_idx = diff2[5:0];
         pos_sel   = req.pos_width;
      end else if ({1'b0, p} >= cfg.temporal_pairs) begin
         local_idx = diff1[5:0];
         pos_sel   = req.pos_height;
      end else begin
         local_idx = p;
         pos_sel   = req.pos_temporal;
      end
   end

   assign expo = {26'd0, local_idx} * {6'd0, cfg.freq_exponent_step};

   assign item.pass     = ({1'b0, p} >= cfg.rotary_pairs) || (int'(p) >= MAX_PAIRS);
   assign item.exp_int  = expo[31:20];
   assign item.exp_frac = expo[19:0];
   assign item.pos      = pos_sel;
   assign item.elem_a   = req.elem_even;
   assign item.elem_b   = req.elem_odd;

endmodule

// ===== rtl/mrp_queue.sv =====
// Short FIFO of classified pairs between front and back.
module mrp_queue import mrp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mrp_item_type  push_item,
   input  logic          pop,
   output mrp_item_type  pop_item,
   output mrp_qstat_type stat
);

   mrp_item_type mem_ff [QDEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign stat.full  = (count_ff == 3'(QDEPTH));
   assign stat.empty = (count_ff == 3'd0);
   assign stat.count = count_ff;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_item   = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, do_push} - {2'b00, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/mrp_back.sv =====
// Back end: frequency multiplier chain, angle in turns, CORDIC rotation,
// gain compensation, rounding and saturation.
module mrp_back import mrp_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int POS_BITS      = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  mrp_qstat_type q_stat,
   input  mrp_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output mrp_rsp_type  rsp_data
);

   localparam int PosW  = (POS_BITS < 20) ? POS_BITS : 20;
   localparam int XW    = 33;
   localparam int ZW    = 34;
   localparam int IdxCrd = ROOT_STEPS + 6;
   localparam int IdxGn  = IdxCrd + CORDIC_STAGES;
   localparam int Depth  = IdxGn + 1;

   typedef struct packed {
      logic               pass;
      logic [11:0]        ei;
      logic [19:0]        ef;
      logic [PosW-1:0]    pos;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic [31:0]        m;
   } root_type;

   typedef struct packed {
      logic               pass;
      logic [11:0]        ei;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic [63:0]        r;
   } rad_type;

   typedef struct packed {
      logic               pass;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic [30:0]        hi;
      logic [30:0]        lo;
   } tml_type;

   typedef struct packed {
      logic               pass;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic [31:0]        turn;
   } tad_type;

   typedef struct packed {
      logic               pass;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } crd_type;

   typedef struct packed {
      logic               pass;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [63:0] px;
      logic signed [63:0] py;
   } gn_type;

   logic              en;
   logic [Depth-1:0]  vld_ff;
   root_type          rt_ff [ROOT_STEPS+1];
   rad_type           mul_ff, shf_ff;
   tml_type           tml_ff;
   tad_type           tad_ff;
   crd_type           crd_ff [CORDIC_STAGES+1];
   gn_type            gn_ff;
   mrp_rsp_type       rsp_ff;
   logic              rsp_valid_ff;

   // whole pipe advances when the output register can take a value
   assign en        = !rsp_valid_ff || rsp_ready;
   assign q_pop     = en && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[Depth-2:0], q_pop};
         rsp_valid_ff <= vld_ff[Depth-1];
      end
   end

   // load from queue, multiplier starts at one
   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff[0].pass <= q_item.pass;
         rt_ff[0].ei   <= q_item.exp_int;
         rt_ff[0].ef   <= q_item.exp_frac;
         rt_ff[0].pos  <= q_item.pos[PosW-1:0];
         rt_ff[0].a    <= q_item.elem_a;
         rt_ff[0].b    <= q_item.elem_b;
         rt_ff[0].m    <= 32'h8000_0000;
      end
   end

   // one root factor per stage for each set fraction bit
   for (genvar k = 1; k <= ROOT_STEPS; k++) begin : g_root
      localparam logic [31:0] RootK = mrp_root(k);
      logic [63:0] prod;
      assign prod = {32'd0, rt_ff[k-1].m} * {32'd0, RootK};
      always_ff @(posedge clock) begin
         if (en) begin
            rt_ff[k] <= rt_ff[k-1];
            if (rt_ff[k-1].ef[ROOT_STEPS-k]) begin
               rt_ff[k].m <= prod[62:31];
            end
         end
      end
   end

   // radians = pos * m, then shift by the integer exponent
   always_ff @(posedge clock) begin
      if (en) begin
         mul_ff.pass <= rt_ff[ROOT_STEPS].pass;
         mul_ff.ei   <= rt_ff[ROOT_STEPS].ei;
         mul_ff.a    <= rt_ff[ROOT_STEPS].a;
         mul_ff.b    <= rt_ff[ROOT_STEPS].b;
         mul_ff.r    <= {{(64-PosW){1'b0}}, rt_ff[ROOT_STEPS].pos}
                        * {32'd0, rt_ff[ROOT_STEPS].m};
         shf_ff      <= mul_ff;
         shf_ff.r    <= (mul_ff.ei >= 12'd63) ? 64'd0 : (mul_ff.r >> mul_ff.ei[5:0]);
      end
   end

   // radians to turns, split in high and low word products
   logic [60:0] hi_prod;
   logic [61:0] lo_prod;
   assign hi_prod = {30'd0, shf_ff.r[62:32]} * {31'd0, INV_TWO_PI_Q32};
   assign lo_prod = {30'd0, shf_ff.r[31:0]} * {32'd0, INV_TWO_PI_Q32};

   always_ff @(posedge clock) begin
      if (en) begin
         tml_ff.pass <= shf_ff.pass;
         tml_ff.a    <= shf_ff.a;
         tml_ff.b    <= shf_ff.b;
         tml_ff.hi   <= hi_prod[30:0];
         tml_ff.lo   <= lo_prod[61:31];
         tad_ff.pass <= tml_ff.pass;
         tad_ff.a    <= tml_ff.a;
         tad_ff.b    <= tml_ff.b;
         tad_ff.turn <= {tml_ff.hi, 1'b0} + {1'b0, tml_ff.lo};
      end
   end

   // quadrant pre-rotation, residual angle in [-1/8, 1/8) turn
   logic [31:0]          turn_rnd;
   logic [1:0]           quad;
   logic [31:0]          zres;
   logic signed [XW-1:0] xa;
   logic signed [XW-1:0] yb;
   logic signed [XW-1:0] xpre;
   logic signed [XW-1:0] ypre;

   assign turn_rnd = tad_ff.turn + 32'h2000_0000;
   assign quad     = turn_rnd[31:30];
   assign zres     = tad_ff.turn - {quad, 30'd0};
   assign xa       = XW'(tad_ff.a) <<< WORK_SHIFT;
   assign yb       = XW'(tad_ff.b) <<< WORK_SHIFT;

   always_comb begin
      case (quad)
         2'd1: begin xpre = -yb; ypre = xa; end
         2'd2: begin xpre = -xa; ypre = -yb; end
         2'd3: begin xpre = yb;  ypre = -xa; end
         default: begin xpre = xa; ypre = yb; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crd_ff[0].pass <= tad_ff.pass;
         crd_ff[0].a    <= tad_ff.a;
         crd_ff[0].b    <= tad_ff.b;
         crd_ff[0].x    <= xpre;
         crd_ff[0].y    <= ypre;
         crd_ff[0].z    <= ZW'(signed'(zres));
      end
   end

   // rotation-mode CORDIC, one micro-rotation per stage
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      localparam logic signed [ZW-1:0] AtanK = ZW'(ATAN_TURNS[k]);
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      assign xs = crd_ff[k].x >>> k;
      assign ys = crd_ff[k].y >>> k;
      always_ff @(posedge clock) begin
         if (en) begin
            crd_ff[k+1] <= crd_ff[k];
            if (!crd_ff[k].z[ZW-1]) begin
               crd_ff[k+1].x <= crd_ff[k].x - ys;
               crd_ff[k+1].y <= crd_ff[k].y + xs;
               crd_ff[k+1].z <= crd_ff[k].z - AtanK;
            end else begin
               crd_ff[k+1].x <= crd_ff[k].x + ys;
               crd_ff[k+1].y <= crd_ff[k].y - xs;
               crd_ff[k+1].z <= crd_ff[k].z + AtanK;
            end
         end
      end
   end

   // gain compensation product
   always_ff @(posedge clock) begin
      if (en) begin
         gn_ff.pass <= crd_ff[CORDIC_STAGES].pass;
         gn_ff.a    <= crd_ff[CORDIC_STAGES].a;
         gn_ff.b    <= crd_ff[CORDIC_STAGES].b;
         gn_ff.px   <= 64'(crd_ff[CORDIC_STAGES].x) * 64'(CORDIC_GAIN_Q31);
         gn_ff.py   <= 64'(crd_ff[CORDIC_STAGES].y) * 64'(CORDIC_GAIN_Q31);
      end
   end

   // round half up, saturate, or pass the pair through
   function automatic logic signed [15:0] round_sat(input logic signed [63:0] v);
      logic signed [63:0] s;
      s = (v + 64'sd17592186044416) >>> 45;
      if (s > 64'sd32767) return 16'sd32767;
      if (s < -64'sd32768) return -16'sd32768;
      return s[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.out_even <= gn_ff.pass ? gn_ff.a : round_sat(gn_ff.px);
         rsp_ff.out_odd  <= gn_ff.pass ? gn_ff.b : round_sat(gn_ff.py);
      end
   end

endmodule

// ===== rtl/mrope_pair_rotator.sv =====
// Top level of the multimodal rotary position embedding pair rotator.
// One element pair is accepted per cycle while the queue is not full, and one rotated
// (or passed-through) pair leaves per cycle when rsp_ready stays high. An accepted
// pair passes from the four-entry queue into the frequency multiplier chain, whose
// first register loads straight from the queue (one multiply per exponent fraction
// bit after it), then the position multiply, shift, two turn conversion steps and
// quadrant step, one register per CORDIC stage, the gain multiply and one output
// register. A stall on the result side holds the whole back end while the queue
// keeps taking pairs until it is full. Registers sit at APB byte offsets 0, 4, 8
// and 12; the user must write them only while the block is idle, which the block
// itself does not enforce.
module mrope_pair_rotator import mrp_pkg::*; #(
   parameter int MAX_PAIRS     = 64,
   parameter int CORDIC_STAGES = 16,
   parameter int POS_BITS      = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mrp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output mrp_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   mrp_cfg_type   cfg_ff;
   mrp_item_type  front_item;
   mrp_item_type  q_item;
   mrp_qstat_type q_stat;
   logic          q_pop;
   logic          cfg_wr;

   // configuration registers
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotary_pairs       <= 7'd64;
         cfg_ff.temporal_pairs     <= 7'd16;
         cfg_ff.height_pairs       <= 7'd24;
         cfg_ff.freq_exponent_step <= 26'd326559;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_ROTARY_PAIRS:   cfg_ff.rotary_pairs       <= pwdata[6:0];
            REG_TEMPORAL_PAIRS: cfg_ff.temporal_pairs     <= pwdata[6:0];
            REG_HEIGHT_PAIRS:   cfg_ff.height_pairs       <= pwdata[6:0];
            REG_FREQ_STEP:      cfg_ff.freq_exponent_step <= pwdata[25:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ROTARY_PAIRS:   prdata = {25'd0, cfg_ff.rotary_pairs};
         REG_TEMPORAL_PAIRS: prdata = {25'd0, cfg_ff.temporal_pairs};
         REG_HEIGHT_PAIRS:   prdata = {25'd0, cfg_ff.height_pairs};
         REG_FREQ_STEP:      prdata = {6'd0, cfg_ff.freq_exponent_step};
         default:            prdata = '0;
      endcase
   end

   assign req_ready = !q_stat.full;

   mrp_front #(
      .MAX_PAIRS(MAX_PAIRS)
   ) u_front (
      .req  (req_data),
      .cfg  (cfg_ff),
      .item (front_item)
   );

   mrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .stat      (q_stat)
   );

   mrp_back #(
      .CORDIC_STAGES(CORDIC_STAGES),
      .POS_BITS     (POS_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // queue fill never exceeds its depth
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= 3'(QDEPTH))
      else $error("queue count beyond depth");

   // front back-pressure only when the queue is full
   a_q_full: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |-> q_stat.full)
      else $error("request stalled with queue space left");

   // nothing is shown on the result side right after reset
   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
